// ===== design/prime_sieve_table_assert.svh =====
// ----------------------------------------------------------------------------
// prime_sieve_table_assert.svh
// Assertion macros shared by the prime sieve table design files
// ----------------------------------------------------------------------------
`ifndef PRIME_SIEVE_TABLE_ASSERT_SVH
`define PRIME_SIEVE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define PST_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PST_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PST_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define PST_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

// ===== design/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg
// Shared constants and types for the prime sieve table
// ----------------------------------------------------------------------------
package pst_pkg;

    // default table size in numbers
    localparam int MAX_NUMBERS_DEFAULT = 65536;

    // field widths
    localparam int LIMIT_W = 17;
    localparam int QUERY_W = 16;

    // limit register value after reset
    localparam int LIMIT_RESET = 65536;

    // action codes
    localparam logic ACT_BUILD = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // status of the sieve engine as seen by the top level
    typedef struct packed {
        logic busy;
        logic finished;
    } pst_stat_t;

endpackage

// ===== design/pst_ram.sv =====
// ----------------------------------------------------------------------------
// pst_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module pst_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pst_sieve.sv =====
// ----------------------------------------------------------------------------
// pst_sieve
// Build sequencer: clears the table, then runs the sieve over the RAM
// ----------------------------------------------------------------------------
`include "prime_sieve_table_assert.svh"

module pst_sieve #(
    parameter int MAX_NUMBERS = pst_pkg::MAX_NUMBERS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           ack,
    input  logic [$clog2(MAX_NUMBERS):0]   elim,
    output pst_pkg::pst_stat_t             stat,
    output logic                           ram_we,
    output logic [$clog2(MAX_NUMBERS)-1:0] ram_waddr,
    output logic                           ram_wdata,
    output logic                           ram_re,
    output logic [$clog2(MAX_NUMBERS)-1:0] ram_raddr,
    input  logic                           ram_rdata
);
    import pst_pkg::*;

    localparam int AW = $clog2(MAX_NUMBERS);
    localparam int EW = AW + 1;
    localparam int IW = (AW + 1) / 2 + 1;
    localparam int SW = AW + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_SEL   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [EW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] i_reg, i_next;
    logic [SW-1:0] sq_reg, sq_next;
    logic [SW-1:0] j_reg, j_next;
    logic [SW-1:0] sq_step;
    logic [SW-1:0] elim_ext;

    assign elim_ext = SW'(elim);

    // (i+1)^2 = i^2 + 2i + 1
    assign sq_step = sq_reg + (SW'(i_reg) << 1) + SW'(1);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        sq_next    = sq_reg;
        j_next     = j_reg;
        ram_we     = 1'b0;
        ram_waddr  = cnt_reg[AW-1:0];
        ram_wdata  = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = AW'(i_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = '0;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                if (cnt_reg < elim)
                begin
                    // zero and one are marked not prime, the rest start unmarked
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg[AW-1:0];
                    ram_wdata = (cnt_reg < EW'(2));
                    cnt_next  = cnt_reg + EW'(1);
                end
                else
                begin
                    i_next     = IW'(2);
                    sq_next    = SW'(4);
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                if (sq_reg < elim_ext)
                begin
                    ram_re     = 1'b1;
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_CHECK:
            begin
                if (ram_rdata)
                begin
                    i_next     = i_reg + IW'(1);
                    sq_next    = sq_step;
                    state_next = S_SEL;
                end
                else
                begin
                    j_next     = sq_reg;
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                if (j_reg < elim_ext)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg[AW-1:0];
                    ram_wdata = 1'b1;
                    j_next    = j_reg + SW'(i_reg);
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    sq_next    = sq_step;
                    state_next = S_SEL;
                end
            end
            S_FIN:
            begin
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // counters and walk pointers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        i_reg   <= i_next;
        sq_reg  <= sq_next;
        j_reg   <= j_next;
    end

    assign stat.busy     = (state_reg != S_IDLE);
    assign stat.finished = (state_reg == S_FIN);

    `PST_ASSERT_IMP(a_mark_below_limit, clk, rst_n,
        state_reg == S_MARK && ram_we, j_reg < elim_ext)
    `PST_ASSERT_NXT(a_read_then_check, clk, rst_n,
        state_reg == S_SEL && ram_re, state_reg == S_CHECK)
    `PST_ASSERT_IMP(a_base_at_least_two, clk, rst_n,
        state_reg == S_CHECK || state_reg == S_MARK, i_reg >= IW'(2))

endmodule

// ===== design/prime_sieve_table.sv =====
// ----------------------------------------------------------------------------
// prime_sieve_table
// Primality table built by the sieve of Eratosthenes, one bit per number
// ----------------------------------------------------------------------------
// query: RAM read, then output reg; one query per cycle unless out stalls or busy
// build: clears the entries below the effective limit, then for each base i with
//   i*i below the limit reads its entry and marks multiples of unmarked bases;
//   one RAM write port sets the pace, one entry a cycle, finish held while out stalls
// reset: table not built, limit 65536 clipped to the table size; the table RAM
//   is not cleared at reset, every build rewrites the entries below the limit
`include "prime_sieve_table_assert.svh"

module prime_sieve_table #(
    parameter int MAX_NUMBERS = pst_pkg::MAX_NUMBERS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pst_pkg::LIMIT_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic [pst_pkg::QUERY_W-1:0] query_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        is_prime,
    output logic                        in_range,
    output logic                        build_done
);
    import pst_pkg::*;

    localparam int AW  = $clog2(MAX_NUMBERS);
    localparam int EW  = AW + 1;
    localparam int CW  = (LIMIT_W > EW) ? LIMIT_W : EW;
    localparam int QCW = (QUERY_W > EW) ? QUERY_W : EW;
    localparam int QXW = (QUERY_W > AW) ? QUERY_W : AW;
    localparam logic [EW-1:0] ELIM_RESET =
        EW'((LIMIT_RESET > MAX_NUMBERS) ? MAX_NUMBERS : LIMIT_RESET);

    pst_stat_t      eng_stat;
    logic           eng_start, eng_ack;
    logic           eng_we, eng_wdata, eng_re;
    logic [AW-1:0]  eng_waddr, eng_raddr;

    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic           ram_rdata;

    logic [EW-1:0]  elim_reg, elim_next;
    logic           built_reg, built_next;
    logic           pend_reg, pend_next;
    logic           hit_reg, hit_next;
    logic           out_valid_reg, out_valid_next;
    logic           prime_reg, prime_next;
    logic           range_reg, range_next;
    logic           done_reg, done_next;

    logic           in_accept, query_accept, out_free, move;
    logic [CW-1:0]  cfg_ext;
    logic [QXW-1:0] q_ext;
    logic           q_below;

    // handshake
    assign out_free     = !out_valid_reg || out_ready;
    assign move         = pend_reg && out_free;
    assign in_ready     = !eng_stat.busy && (!pend_reg || move);
    assign in_accept    = in_valid && in_ready;
    assign query_accept = in_accept && (action == ACT_QUERY);
    assign eng_start    = in_accept && (action == ACT_BUILD);
    assign eng_ack      = eng_stat.finished && out_free;

    // query address and range test
    assign q_ext     = QXW'(query_value);
    assign q_below   = QCW'(query_value) < QCW'(elim_reg);
    assign cfg_ext   = CW'(cfg_wdata);

    // RAM read port: engine while building, queries otherwise
    assign ram_re    = eng_stat.busy ? eng_re : query_accept;
    assign ram_raddr = eng_stat.busy ? eng_raddr : q_ext[AW-1:0];

    pst_sieve #(
        .MAX_NUMBERS(MAX_NUMBERS)
    ) u_sieve (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (eng_start),
        .ack       (eng_ack),
        .elim      (elim_reg),
        .stat      (eng_stat),
        .ram_we    (eng_we),
        .ram_waddr (eng_waddr),
        .ram_wdata (eng_wdata),
        .ram_re    (eng_re),
        .ram_raddr (eng_raddr),
        .ram_rdata (ram_rdata)
    );

    pst_ram #(
        .WIDTH(1),
        .DEPTH(MAX_NUMBERS)
    ) u_map (
        .clk   (clk),
        .we    (eng_we),
        .waddr (eng_waddr),
        .wdata (eng_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // limit register and built flag
    always_comb
    begin
        elim_next  = elim_reg;
        built_next = built_reg;
        if (cfg_we)
        begin
            elim_next  = (cfg_ext > CW'(MAX_NUMBERS)) ? EW'(MAX_NUMBERS) : cfg_ext[EW-1:0];
            built_next = 1'b0;
        end
        else if (eng_ack)
        begin
            built_next = 1'b1;
        end
    end

    // query in flight while the RAM read completes
    always_comb
    begin
        pend_next = pend_reg;
        hit_next  = hit_reg;
        if (query_accept)
        begin
            pend_next = 1'b1;
            hit_next  = built_reg && q_below;
        end
        else if (move)
        begin
            pend_next = 1'b0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        prime_next     = prime_reg;
        range_next     = range_reg;
        done_next      = done_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
            prime_next     = hit_reg && !ram_rdata;
            range_next     = hit_reg;
            done_next      = 1'b0;
        end
        else if (eng_ack)
        begin
            out_valid_next = 1'b1;
            prime_next     = 1'b0;
            range_next     = 1'b0;
            done_next      = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elim_reg      <= ELIM_RESET;
            built_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            elim_reg      <= elim_next;
            built_reg     <= built_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        prime_reg <= prime_next;
        range_reg <= range_next;
        done_reg  <= done_next;
    end

    assign out_valid  = out_valid_reg;
    assign is_prime   = prime_reg;
    assign in_range   = range_reg;
    assign build_done = done_reg;

    `PST_ASSERT_IMP(a_ready_not_building, clk, rst_n, in_ready, !eng_stat.busy)
    `PST_ASSERT_IMP(a_no_query_in_build, clk, rst_n, eng_stat.busy, !pend_reg)
    `PST_ASSERT_NXT(a_ack_loads_result, clk, rst_n,
        eng_ack, out_valid_reg && done_reg && built_reg)

endmodule
